@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the RTL of the matrix multiply block; the top module includes them.
// Every check samples on the rising edge of clock and is off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent implies the consequent at the same edge.
`define ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The condition never holds.
`define ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`endif

@@ hdl/imm_pkg.sv @@
// ----------------------------------------------------------------------------
// imm_pkg
// Types and fixed widths shared by the integer matrix multiply modules.
// ----------------------------------------------------------------------------
package imm_pkg;

   // Fixed field widths.
   localparam int WORD_W  = 32;
   localparam int INDEX_W = 4;
   localparam int SIZE_W  = 5;
   localparam int ACT_W   = 2;

   // Size register value after reset.
   localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

   // Request actions; the fourth code does nothing.
   typedef enum logic [ACT_W-1:0] {
      ACT_WRITE_A = 2'd0,
      ACT_WRITE_B = 2'd1,
      ACT_QUERY   = 2'd2
   } imm_action_type;

   // Control that travels with one term into the multiply-accumulate unit.
   typedef struct packed {
      logic clear;   // start a new dot product
      logic valid;   // read data holds a term this cycle
      logic last;    // this term closes the dot product
   } imm_mac_ctl_type;

endpackage

@@ hdl/integer_matrix_multiply.sv @@
// ----------------------------------------------------------------------------
// integer_matrix_multiply
// Dense square integer matrix product C = A*B held in two element memories.
//
// A write of an element of A or B gives no result, and a write outside the
// active size is dropped. A query whose row or column lies outside the active
// size answers on the next cycle with product zero and index_ok low. An
// in-range query streams one term of row i of A and column j of B per cycle
// out of the two memory read ports into a pipelined multiply-accumulate, over
// n terms, where n is the active size (the size register limited to MAX_DIM);
// the result passes the read data, product and accumulator registers. Each
// result is on the rsp_ ports for exactly one cycle with rsp_valid high and
// must be taken then.
// Reading an element never written since reset returns an undefined value.
// ----------------------------------------------------------------------------
module integer_matrix_multiply
   import imm_pkg::*;
#(
   parameter int MAX_DIM = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   // Configuration
   input  logic                     csr_write,
   input  logic [SIZE_W-1:0]        csr_wdata,
   // Requests
   input  logic                     start,
   output logic                     busy,
   input  logic [ACT_W-1:0]         req_action,
   input  logic [INDEX_W-1:0]       req_row,
   input  logic [INDEX_W-1:0]       req_col,
   input  logic signed [WORD_W-1:0] req_value,
   // Results
   output logic                     rsp_valid,
   output logic [INDEX_W-1:0]       rsp_out_row,
   output logic [INDEX_W-1:0]       rsp_out_col,
   output logic signed [WORD_W-1:0] rsp_product,
   output logic                     rsp_index_ok
);

`include "assert_macros.svh"

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = ($clog2(MAX_DIM + 1) > SIZE_W) ? $clog2(MAX_DIM + 1) : SIZE_W;
   localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_DIM);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN
   } state_type;

   state_type          state_ff;
   logic [SIZE_W-1:0]  size_ff;
   logic [CNT_W-1:0]   k_ff;
   logic [INDEX_W-1:0] row_ff;
   logic [INDEX_W-1:0] col_ff;
   logic               rd_valid_ff;
   logic               rd_last_ff;
   logic               rsp_valid_ff;
   logic [INDEX_W-1:0] rsp_row_ff;
   logic [INDEX_W-1:0] rsp_col_ff;
   logic [WORD_W-1:0]  rsp_product_ff;
   logic               rsp_ok_ff;

   logic [CNT_W-1:0]   size_w;
   logic [CNT_W-1:0]   active_n;
   logic               accept;
   logic               in_range;
   logic               is_write_a;
   logic               is_write_b;
   logic               is_query;
   logic               issue_last;
   logic [ADDR_W-1:0]  wr_addr;
   logic [ADDR_W-1:0]  rd_addr_a;
   logic [ADDR_W-1:0]  rd_addr_b;
   logic [WORD_W-1:0]  rd_data_a;
   logic [WORD_W-1:0]  rd_data_b;
   logic               wr_en_a;
   logic               wr_en_b;
   imm_mac_ctl_type    mac_ctl;
   logic               mac_done;
   logic [WORD_W-1:0]  mac_sum;

   // Active size, limited to the storage bound.
   assign size_w   = CNT_W'(size_ff);
   assign active_n = (size_w > MAX_N) ? MAX_N : size_w;

   // Request decode.
   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start & ~busy;
   assign in_range = (CNT_W'(req_row) < active_n) && (CNT_W'(req_col) < active_n);

   always_comb begin
      is_write_a = 1'b0;
      is_write_b = 1'b0;
      is_query   = 1'b0;
      case (imm_action_type'(req_action))
         ACT_WRITE_A: is_write_a = 1'b1;
         ACT_WRITE_B: is_write_b = 1'b1;
         ACT_QUERY:   is_query   = 1'b1;
         default: begin
         end
      endcase
   end

   // Element writes go straight to the memories on the accepting edge.
   assign wr_en_a = accept & is_write_a & in_range;
   assign wr_en_b = accept & is_write_b & in_range;
   assign wr_addr = ADDR_W'(32'(req_row) * MAX_DIM + 32'(req_col));

   // Read addresses for term k: A[row][k] and B[k][col].
   assign rd_addr_a  = ADDR_W'(32'(row_ff) * MAX_DIM + 32'(k_ff));
   assign rd_addr_b  = ADDR_W'(32'(k_ff) * MAX_DIM + 32'(col_ff));
   assign issue_last = (k_ff == active_n - CNT_W'(1));

   // Size register.
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
      end else if (csr_write) begin
         size_ff <= csr_wdata;
      end
   end

   // Query sequencer and result strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= '0;
         rd_valid_ff  <= 1'b0;
         rd_last_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff  <= (state_ff == ST_ISSUE);
         rd_last_ff   <= (state_ff == ST_ISSUE) & issue_last;
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept && is_query) begin
                  if (in_range) begin
                     state_ff <= ST_ISSUE;
                     k_ff     <= '0;
                  end else begin
                     rsp_valid_ff <= 1'b1;
                  end
               end
            end
            ST_ISSUE: begin
               k_ff <= k_ff + CNT_W'(1);
               if (issue_last) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (mac_done) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Query indices and result payload.
   always_ff @(posedge clock) begin
      if (accept && is_query) begin
         row_ff     <= req_row;
         col_ff     <= req_col;
         rsp_row_ff <= req_row;
         rsp_col_ff <= req_col;
         if (!in_range) begin
            rsp_product_ff <= '0;
            rsp_ok_ff      <= 1'b0;
         end
      end else if (state_ff == ST_DRAIN && mac_done) begin
         rsp_product_ff <= mac_sum;
         rsp_ok_ff      <= 1'b1;
      end
   end

   assign mac_ctl.clear = accept & is_query & in_range;
   assign mac_ctl.valid = rd_valid_ff;
   assign mac_ctl.last  = rd_last_ff;

   imm_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock     (clock),
      .wr_en_a   (wr_en_a),
      .wr_en_b   (wr_en_b),
      .wr_addr   (wr_addr),
      .wr_data   (req_value),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   imm_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mac_ctl),
      .term_a (rd_data_a),
      .term_b (rd_data_b),
      .done   (mac_done),
      .sum    (mac_sum)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_row  = rsp_row_ff;
   assign rsp_out_col  = rsp_col_ff;
   assign rsp_product  = rsp_product_ff;
   assign rsp_index_ok = rsp_ok_ff;

   // The accumulator finishes only while the sequencer waits for it.
   `ASSERT_IMPLY(a_done_in_drain, mac_done, state_ff == ST_DRAIN,
      "dot product finished outside the drain state")

   // The term counter stays inside the active size while terms are issued.
   `ASSERT_IMPLY(a_k_in_range, state_ff == ST_ISSUE, k_ff < active_n,
      "term index beyond the active size")

   // No element write lands while a query is reading the memories.
   `ASSERT_NEVER(a_no_write_in_query, (wr_en_a || wr_en_b) && state_ff != ST_IDLE,
      "element write during a query")

   // An out-of-range result carries a zero product.
   `ASSERT_IMPLY(a_bad_index_zero, rsp_valid && !rsp_index_ok, rsp_product == '0,
      "out-of-range result with nonzero product")

endmodule

@@ hdl/imm_store.sv @@
// ----------------------------------------------------------------------------
// imm_store
// Element storage for both matrices: one synchronous memory each, one write
// port and one read port with registered read data.
// ----------------------------------------------------------------------------
module imm_store
   import imm_pkg::*;
#(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en_a,
   input  logic              wr_en_b,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WORD_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [WORD_W-1:0] rd_data_a,
   output logic [WORD_W-1:0] rd_data_b
);

   logic [WORD_W-1:0] mem_a [DEPTH];
   logic [WORD_W-1:0] mem_b [DEPTH];
   logic [WORD_W-1:0] rd_a_ff;
   logic [WORD_W-1:0] rd_b_ff;

   // Left matrix: write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en_a) begin
         mem_a[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_a[rd_addr_a];
   end

   // Right matrix: write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en_b) begin
         mem_b[wr_addr] <= wr_data;
      end
      rd_b_ff <= mem_b[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

@@ hdl/imm_mac.sv @@
// ----------------------------------------------------------------------------
// imm_mac
// Two-stage multiply-accumulate: a registered 32 x 32 product, then a
// wrapping 32-bit accumulator. Signals done for one cycle after the last term.
// ----------------------------------------------------------------------------
module imm_mac
   import imm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  imm_mac_ctl_type   ctl,
   input  logic [WORD_W-1:0] term_a,
   input  logic [WORD_W-1:0] term_b,
   output logic              done,
   output logic [WORD_W-1:0] sum
);

   logic [WORD_W-1:0] prod_ff;
   logic              prod_valid_ff;
   logic              prod_last_ff;
   logic [WORD_W-1:0] acc_ff;
   logic              done_ff;

   // Control pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         prod_last_ff  <= 1'b0;
         done_ff       <= 1'b0;
      end else begin
         prod_valid_ff <= ctl.valid;
         prod_last_ff  <= ctl.valid & ctl.last;
         done_ff       <= prod_valid_ff & prod_last_ff;
      end
   end

   // Product stage: only the low word matters, so the sign is irrelevant.
   always_ff @(posedge clock) begin
      prod_ff <= term_a * term_b;
   end

   // Accumulator stage, cleared when a dot product starts.
   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         acc_ff <= '0;
      end else if (prod_valid_ff) begin
         acc_ff <= acc_ff + prod_ff;
      end
   end

   assign done = done_ff;
   assign sum  = acc_ff;

endmodule

@@ tb/sv/imm_product_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imm_product_checker
// Watches the request, result and size-register ports of the integer matrix
// multiply block, keeps its own copy of both matrices and the active size,
// predicts each product beat and compares every result beat field by field.
// ----------------------------------------------------------------------------
module imm_product_checker
   import imm_pkg::*;
#(
   parameter int MAX_DIM = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write,
   input  logic [SIZE_W-1:0]        csr_wdata,
   input  logic                     start,
   input  logic                     busy,
   input  logic [ACT_W-1:0]         req_action,
   input  logic [INDEX_W-1:0]       req_row,
   input  logic [INDEX_W-1:0]       req_col,
   input  logic signed [WORD_W-1:0] req_value,
   input  logic                     rsp_valid,
   input  logic [INDEX_W-1:0]       rsp_out_row,
   input  logic [INDEX_W-1:0]       rsp_out_col,
   input  logic signed [WORD_W-1:0] rsp_product,
   input  logic                     rsp_index_ok,
   output int                       fail_count,
   output int                       pending,
   output int                       checked
);

   typedef struct {
      logic [INDEX_W-1:0] row;
      logic [INDEX_W-1:0] col;
      logic [WORD_W-1:0]  product;
      logic               index_ok;
   } product_beat_type;

   // Shadow copies of both matrices, row-major, and of the size register.
   logic [WORD_W-1:0] a_words [MAX_DIM*MAX_DIM];
   logic [WORD_W-1:0] b_words [MAX_DIM*MAX_DIM];
   logic [SIZE_W-1:0] size_reg;
   product_beat_type  products_due [$];

   // Sizes above the bound act as the bound.
   function automatic int unsigned used_dim();
      return (size_reg > MAX_DIM) ? MAX_DIM : size_reg;
   endfunction

   // Row of A times column of B; every product and sum wraps at 32 bits.
   function automatic logic [WORD_W-1:0] predict_element(input int unsigned r,
                                                         input int unsigned c,
                                                         input int unsigned n);
      logic [WORD_W-1:0] acc;
      acc = '0;
      for (int unsigned k = 0; k < n; k++) begin
         acc = acc + a_words[r*MAX_DIM + k] * b_words[k*MAX_DIM + c];
      end
      return acc;
   endfunction

   task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                  input logic [WORD_W-1:0] wanted);
      $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, wanted);
      fail_count++;
   endtask

   always @(posedge clock) begin
      product_beat_type want;
      product_beat_type beat;
      int unsigned      n;
      logic             in_range;
      int unsigned      idx;
      if (reset) begin
         size_reg = SIZE_RESET;
         products_due.delete();
         for (int i = 0; i < MAX_DIM*MAX_DIM; i++) begin
            a_words[i] = '0;
            b_words[i] = '0;
         end
      end else begin
         if (csr_write) begin
            size_reg = csr_wdata;
         end

         // Result beats first: a beat never answers a query taken at the same edge.
         if (rsp_valid) begin
            if (products_due.size() == 0) begin
               report_mismatch("result beat with no query outstanding", rsp_product, '0);
            end else begin
               want = products_due.pop_front();
               if (rsp_out_row !== want.row)
                  report_mismatch("out_row", rsp_out_row, want.row);
               if (rsp_out_col !== want.col)
                  report_mismatch("out_col", rsp_out_col, want.col);
               if (rsp_product !== want.product)
                  report_mismatch("product", rsp_product, want.product);
               if (rsp_index_ok !== want.index_ok)
                  report_mismatch("index_ok", rsp_index_ok, want.index_ok);
               checked++;
            end
         end

         // Request beat: update the shadow matrices or queue the expected product.
         if (start && !busy) begin
            n = used_dim();
            in_range = (req_row < n) && (req_col < n);
            idx = int'(req_row) * MAX_DIM + int'(req_col);
            case (imm_action_type'(req_action))
               ACT_WRITE_A: begin
                  if (in_range) a_words[idx] = req_value;
               end
               ACT_WRITE_B: begin
                  if (in_range) b_words[idx] = req_value;
               end
               ACT_QUERY: begin
                  beat.row = req_row;
                  beat.col = req_col;
                  beat.product = in_range ? predict_element(req_row, req_col, n) : '0;
                  beat.index_ok = in_range;
                  products_due.push_back(beat);
               end
               default: ;
            endcase
         end
      end
      pending = products_due.size();
   end

endmodule

@@ tb/sv/integer_matrix_multiply_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_matrix_multiply_tb
// Drives element writes and product queries into the matrix multiply block
// under a range of active sizes and sender gap rates; a checker beside the
// block predicts every product beat and counts mismatches for the verdict.
// ----------------------------------------------------------------------------
module integer_matrix_multiply_tb;
   import imm_pkg::*;

   localparam int MAX_DIM      = 16;
   localparam int RANDOM_ITEMS = 1260;
   localparam int PHASES       = 9;
   localparam int DRAIN_CYCLES = 24;
   localparam int CYCLE_LIMIT  = 400000;

   // The fourth action code does nothing.
   localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;

   // Active size for each random phase; the extremes are among them.
   localparam logic [SIZE_W-1:0] PHASE_SIZE [PHASES] = '{
      5'd16, 5'd1, 5'd31, 5'd2, 5'd0, 5'd9, 5'd17, 5'd16, 5'd5};

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_write = 1'b0;
   logic [SIZE_W-1:0]        csr_wdata = '0;
   logic                     start = 1'b0;
   logic                     busy;
   logic [ACT_W-1:0]         req_action = '0;
   logic [INDEX_W-1:0]       req_row = '0;
   logic [INDEX_W-1:0]       req_col = '0;
   logic signed [WORD_W-1:0] req_value = '0;
   logic                     rsp_valid;
   logic [INDEX_W-1:0]       rsp_out_row;
   logic [INDEX_W-1:0]       rsp_out_col;
   logic signed [WORD_W-1:0] rsp_product;
   logic                     rsp_index_ok;

   int          fail_count;
   int          pending;
   int          checked;
   int          cycle_count = 0;
   int          beats_sent = 0;
   int          size_writes = 0;
   int unsigned gap_pct = 0;
   logic [SIZE_W-1:0] size_now = SIZE_RESET;

   // 20 ns clock.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   integer_matrix_multiply #(.MAX_DIM(MAX_DIM)) uut (
      .clock        (clock),
      .reset        (reset),
      .csr_write    (csr_write),
      .csr_wdata    (csr_wdata),
      .start        (start),
      .busy         (busy),
      .req_action   (req_action),
      .req_row      (req_row),
      .req_col      (req_col),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_out_row  (rsp_out_row),
      .rsp_out_col  (rsp_out_col),
      .rsp_product  (rsp_product),
      .rsp_index_ok (rsp_index_ok)
   );

   imm_product_checker #(.MAX_DIM(MAX_DIM)) u_checker (
      .clock        (clock),
      .reset        (reset),
      .csr_write    (csr_write),
      .csr_wdata    (csr_wdata),
      .start        (start),
      .busy         (busy),
      .req_action   (req_action),
      .req_row      (req_row),
      .req_col      (req_col),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_out_row  (rsp_out_row),
      .rsp_out_col  (rsp_out_col),
      .rsp_product  (rsp_product),
      .rsp_index_ok (rsp_index_ok),
      .fail_count   (fail_count),
      .pending      (pending),
      .checked      (checked)
   );

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("run timed out after %0d cycles with %0d results outstanding",
                  cycle_count, pending);
         $display("status: fail");
         $finish;
      end
   end

   // Mostly random words, with the signed extremes, all ones and zero mixed in.
   function automatic logic [WORD_W-1:0] rand_word();
      case ($urandom_range(15))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return '1;
         3: return '0;
         default: return $urandom();
      endcase
   endfunction

   // Present one request beat at the falling edge and hold it until taken.
   // Start stays high on return so back-to-back beats need no extra edge.
   task automatic send_item(input logic [ACT_W-1:0] act, input logic [INDEX_W-1:0] r,
                            input logic [INDEX_W-1:0] c, input logic [WORD_W-1:0] v);
      if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < gap_pct);
      end
      req_action <= act;
      req_row <= r;
      req_col <= c;
      req_value <= v;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      beats_sent++;
      @(negedge clock);
   endtask

   // Stop sending and wait until every queued product beat has come back.
   task automatic drain_results();
      start <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
   endtask

   // Change the active size only once the block has gone quiet.
   task automatic write_size(input logic [SIZE_W-1:0] value);
      drain_results();
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_write <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      size_now = value;
      size_writes++;
   endtask

   // One random step: mostly in-range writes and queries, some row and
   // column refreshes followed by their query, and a little noise.
   task automatic random_item();
      int unsigned       n;
      int unsigned       pick;
      logic [INDEX_W-1:0] r;
      logic [INDEX_W-1:0] c;
      logic [ACT_W-1:0]  act;
      n = (size_now > MAX_DIM) ? MAX_DIM : size_now;
      pick = (n == 0) ? 90 : $urandom_range(99);
      r = (n == 0) ? '0 : INDEX_W'($urandom_range(n - 1));
      c = (n == 0) ? '0 : INDEX_W'($urandom_range(n - 1));
      if (pick < 35) begin
         act = $urandom_range(1) ? ACT_WRITE_B : ACT_WRITE_A;
         send_item(act, r, c, rand_word());
      end else if (pick < 75) begin
         send_item(ACT_QUERY, r, c, rand_word());
      end else if (pick < 85) begin
         for (int unsigned k = 0; k < n; k++) begin
            send_item(ACT_WRITE_A, r, INDEX_W'(k), rand_word());
            send_item(ACT_WRITE_B, INDEX_W'(k), c, rand_word());
         end
         send_item(ACT_QUERY, r, c, rand_word());
      end else if (pick < 95) begin
         case ($urandom_range(2))
            0: act = ACT_WRITE_A;
            1: act = ACT_WRITE_B;
            default: act = ACT_QUERY;
         endcase
         send_item(act, INDEX_W'($urandom_range(15)), INDEX_W'($urandom_range(15)),
                   rand_word());
      end else begin
         send_item(ACT_NONE, INDEX_W'($urandom_range(15)), INDEX_W'($urandom_range(15)),
                   rand_word());
      end
      if ($urandom_range(49) == 0) drain_results();
   endtask

   initial begin
      int target;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Fill both matrices so that no query ever reads an unwritten element.
      for (int r = 0; r < MAX_DIM; r++) begin
         for (int c = 0; c < MAX_DIM; c++) begin
            send_item(ACT_WRITE_A, INDEX_W'(r), INDEX_W'(c), $urandom());
            send_item(ACT_WRITE_B, INDEX_W'(r), INDEX_W'(c), $urandom());
         end
      end

      // Field extremes and the unused action at the reset size.
      send_item(ACT_WRITE_A, 4'd15, 4'd15, 32'h8000_0000);
      send_item(ACT_WRITE_B, 4'd15, 4'd15, 32'h7fff_ffff);
      send_item(ACT_WRITE_A, 4'd0, 4'd0, '1);
      send_item(ACT_WRITE_B, 4'd0, 4'd0, '1);
      send_item(ACT_QUERY, 4'd15, 4'd15, '0);
      send_item(ACT_QUERY, 4'd0, 4'd0, '0);
      send_item(ACT_QUERY, 4'd0, 4'd15, '1);
      send_item(ACT_NONE, 4'd15, 4'd15, '1);
      send_item(ACT_QUERY, 4'd15, 4'd15, '0);

      // Out-of-range writes are dropped and out-of-range queries answer zero.
      write_size(5'd3);
      send_item(ACT_WRITE_A, 4'd5, 4'd1, '0);
      send_item(ACT_WRITE_B, 4'd2, 4'd7, '0);
      send_item(ACT_QUERY, 4'd5, 4'd1, '0);
      send_item(ACT_WRITE_A, 4'd2, 4'd2, 32'h7fff_ffff);
      send_item(ACT_QUERY, 4'd2, 4'd2, '0);

      // With size zero nothing is in range.
      write_size(5'd0);
      send_item(ACT_WRITE_A, 4'd0, 4'd0, 32'd1);
      send_item(ACT_QUERY, 4'd0, 4'd0, '0);

      // A size above the bound acts as the bound.
      write_size(5'd31);
      send_item(ACT_WRITE_B, 4'd15, 4'd0, 32'h8000_0000);
      send_item(ACT_QUERY, 4'd15, 4'd0, '0);
      send_item(ACT_QUERY, 4'd15, 4'd15, '0);

      // Size one: one term per product.
      write_size(5'd1);
      send_item(ACT_QUERY, 4'd0, 4'd0, '0);
      send_item(ACT_QUERY, 4'd1, 4'd0, '0);
      send_item(ACT_QUERY, 4'd0, 4'd1, '0);

      // Random phases: sender gaps at 19 percent, then 48, then none.
      for (int p = 0; p < PHASES; p++) begin
         gap_pct = (p < 3) ? 19 : (p < 6) ? 48 : 0;
         write_size(PHASE_SIZE[p]);
         target = beats_sent + RANDOM_ITEMS / PHASES;
         while (beats_sent < target) random_item();
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d request beats across %0d size settings, sizes 0, 1, 16 and 31 included.",
               beats_sent, size_writes);
      $display("Checked %0d product beats, in range and out of range, with %0d mismatches.",
               checked, fail_count);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+hdl
hdl/imm_pkg.sv
hdl/imm_store.sv
hdl/imm_mac.sv
hdl/integer_matrix_multiply.sv
tb/sv/imm_product_checker.sv
tb/sv/integer_matrix_multiply_tb.sv
